// ===== rtl/core/convex_polyhedron_point_query_defines.svh =====
// assertion macros shared by the rtl of the point query block
`ifndef CONVEX_POLYHEDRON_POINT_QUERY_DEFINES_SVH
`define CONVEX_POLYHEDRON_POINT_QUERY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define CPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpq assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpq assertion failed");

`else

`define CPQ_ASSERT_IMP(lbl, ante, cons)
`define CPQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/cpq_pkg.sv =====
package cpq_pkg;

  localparam int MAX_FACES  = 64;
  localparam int SLOT_W     = $clog2(MAX_FACES);
  localparam int CNT_W      = 7;
  localparam int NRM_W      = 18;
  localparam int COORD_W    = 32;
  localparam int OFF_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = NRM_W + COORD_W;
  // three products plus aligned offset, exact
  localparam int DIST_W     = PROD_W + 2;
  localparam int OUT_DIST_W = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EPS        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 1'd1;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // per-face tag travelling with the dot product pipeline
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } tag_t;

endpackage

// ===== rtl/core/convex_polyhedron_point_query.sv =====
// channel   direction  handshake             payload
// in_*      input      in_valid / in_stall   cmd, face_slot, normal_x/y/z, plane_offset,
//                                            point_x/y/z
// out_*     output     out_valid / out_stall point_inside, face_found,
//                                            nearest_outside_face, outside_distance
// cfg_*     input      cfg_we                cfg_index, cfg_data
//
// a load transaction is written to the face memory at accept
// a query reads n faces, n = face_count capped at 64, or goes straight to posting when n is zero:
// one memory read a cycle, a two-stage dot product unit, a compare stage, then the post
// in_stall is high while a query is at work; a result waiting on out_stall does not block
// loads or the next query accept, only the posting of the next result
// synchronous active-low reset clears control state; the face memory has no reset
`include "convex_polyhedron_point_query_defines.svh"

module convex_polyhedron_point_query (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [cpq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cpq_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_cmd,
  input  logic [cpq_pkg::SLOT_W-1:0]             in_face_slot,
  input  logic signed [cpq_pkg::NRM_W-1:0]       in_normal_x,
  input  logic signed [cpq_pkg::NRM_W-1:0]       in_normal_y,
  input  logic signed [cpq_pkg::NRM_W-1:0]       in_normal_z,
  input  logic signed [cpq_pkg::OFF_W-1:0]       in_plane_offset,
  input  logic signed [cpq_pkg::COORD_W-1:0]     in_point_x,
  input  logic signed [cpq_pkg::COORD_W-1:0]     in_point_y,
  input  logic signed [cpq_pkg::COORD_W-1:0]     in_point_z,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_point_inside,
  output logic                                   out_face_found,
  output logic [cpq_pkg::SLOT_W-1:0]             out_nearest_outside_face,
  output logic [cpq_pkg::OUT_DIST_W-1:0]         out_outside_distance
);

  localparam int EPS_EXT_W = cpq_pkg::DIST_W - cpq_pkg::CFG_DATA_W - cpq_pkg::FRAC_W;
  localparam int SH_W      = cpq_pkg::DIST_W - cpq_pkg::FRAC_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // one face memory entry
  typedef struct packed {
    logic signed [cpq_pkg::NRM_W-1:0] nx;
    logic signed [cpq_pkg::NRM_W-1:0] ny;
    logic signed [cpq_pkg::NRM_W-1:0] nz;
    logic signed [cpq_pkg::OFF_W-1:0] off;
  } face_t;

  state_t                                state_r, state_nxt;
  logic signed [cpq_pkg::CFG_DATA_W-1:0] eps_r;
  logic [cpq_pkg::CNT_W-1:0]             face_count_r;
  logic [cpq_pkg::CNT_W-1:0]             n_r, n_nxt;
  logic [cpq_pkg::CNT_W-1:0]             iss_r, iss_nxt;
  logic signed [cpq_pkg::COORD_W-1:0]    pt_x_r, pt_y_r, pt_z_r;

  face_t                                 face_mem [cpq_pkg::MAX_FACES];
  face_t                                 rd_face_r;
  face_t                                 wr_face;
  logic                                  mem_we;
  logic [cpq_pkg::SLOT_W-1:0]            rd_addr;
  cpq_pkg::tag_t                         tag1_r, tag1_nxt;

  cpq_pkg::tag_t                         dot_tag;
  logic signed [cpq_pkg::DIST_W-1:0]     dot_dist;
  logic                                  dot_busy;

  logic                                  found_r, found_nxt;
  logic [cpq_pkg::SLOT_W-1:0]            best_i_r, best_i_nxt;
  logic signed [cpq_pkg::DIST_W-1:0]     best_d_r, best_d_nxt;
  logic signed [cpq_pkg::DIST_W-1:0]     eps_q;
  logic [SH_W-1:0]                       best_sh;
  logic [cpq_pkg::OUT_DIST_W-1:0]        dist_sat;

  logic                                  in_acc, load_acc, query_acc;
  logic                                  issue, drain_done, out_free, post;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r        <= '0;
      face_count_r <= cpq_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpq_pkg::CFG_EPS:        eps_r        <= cfg_data;
        cpq_pkg::CFG_FACE_COUNT: face_count_r <= cfg_data[cpq_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_cmd == cpq_pkg::CMD_LOAD);
  assign query_acc = in_acc && (in_cmd == cpq_pkg::CMD_QUERY);

  // slots past the table are dropped
  assign mem_we  = load_acc &&
                   (cpq_pkg::CNT_W'(in_face_slot) < cpq_pkg::CNT_W'(cpq_pkg::MAX_FACES));
  assign wr_face = '{nx: in_normal_x, ny: in_normal_y, nz: in_normal_z, off: in_plane_offset};
  assign rd_addr = iss_r[cpq_pkg::SLOT_W-1:0];

  // face memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      face_mem[in_face_slot] <= wr_face;
    end
    rd_face_r <= face_mem[rd_addr];
  end

  // face issue sequencer
  assign issue      = (state_r == ST_RUN) && (iss_r < n_r);
  assign drain_done = (state_r == ST_RUN) && (iss_r == n_r) && !tag1_r.valid && !dot_busy;
  assign out_free   = !out_valid || !out_stall;
  assign post       = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    iss_nxt   = iss_r;
    n_nxt     = n_r;
    tag1_nxt  = '{valid: issue, idx: rd_addr};
    unique case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          // face count saturates at the table depth
          n_nxt     = (face_count_r > cpq_pkg::CNT_W'(cpq_pkg::MAX_FACES))
                    ? cpq_pkg::CNT_W'(cpq_pkg::MAX_FACES) : face_count_r;
          iss_nxt   = '0;
          state_nxt = (n_nxt == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          iss_nxt = iss_r + cpq_pkg::CNT_W'(1);
        end
        if (drain_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (post) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tag1_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tag1_r  <= tag1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r <= iss_nxt;
    n_r   <= n_nxt;
    if (query_acc) begin
      pt_x_r <= in_point_x;
      pt_y_r <= in_point_y;
      pt_z_r <= in_point_z;
    end
  end

  cpq_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (tag1_r),
    .nrm_x    (rd_face_r.nx),
    .nrm_y    (rd_face_r.ny),
    .nrm_z    (rd_face_r.nz),
    .offset   (rd_face_r.off),
    .pt_x     (pt_x_r),
    .pt_y     (pt_y_r),
    .pt_z     (pt_z_r),
    .out_tag  (dot_tag),
    .dist_out (dot_dist),
    .busy     (dot_busy)
  );

  // running minimum over distances above eps, first index wins ties
  assign eps_q = {{EPS_EXT_W{eps_r[cpq_pkg::CFG_DATA_W-1]}}, eps_r, {cpq_pkg::FRAC_W{1'b0}}};

  always_comb begin
    found_nxt  = found_r;
    best_i_nxt = best_i_r;
    best_d_nxt = best_d_r;
    if (query_acc) begin
      found_nxt  = 1'b0;
      best_i_nxt = '0;
      best_d_nxt = '0;
    end else if (dot_tag.valid && (dot_dist > eps_q) && (!found_r || (dot_dist < best_d_r))) begin
      found_nxt  = 1'b1;
      best_i_nxt = dot_tag.idx;
      best_d_nxt = dot_dist;
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    best_i_r <= best_i_nxt;
    best_d_r <= best_d_nxt;
  end

  // q.32 to unsigned q15.16 by floor, clamped to 0 .. 2^31-1; negative distances report zero
  always_comb begin
    best_sh  = best_d_r[cpq_pkg::DIST_W-1:cpq_pkg::FRAC_W];
    dist_sat = '0;
    if (found_r && !best_d_r[cpq_pkg::DIST_W-1] && (best_d_r != '0)) begin
      if (|best_sh[SH_W-1:cpq_pkg::OUT_DIST_W]) begin
        dist_sat = '1;
      end else begin
        dist_sat = best_sh[cpq_pkg::OUT_DIST_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      out_point_inside         <= !found_r;
      out_face_found           <= found_r;
      out_nearest_outside_face <= found_r ? best_i_r : '0;
      out_outside_distance     <= dist_sat;
    end
  end

  // a query always leaves idle
  `CPQ_ASSERT_NXT(a_query_starts, query_acc, (state_r == ST_RUN) || (state_r == ST_DONE))
  // dot unit results only arrive while a query runs
  `CPQ_ASSERT_IMP(a_dot_in_run, dot_tag.valid, state_r == ST_RUN)
  // issue pointer never passes the face count
  `CPQ_ASSERT_IMP(a_iss_bound, state_r == ST_RUN, iss_r <= n_r)
  // inside and found are exclusive on every result
  `CPQ_ASSERT_IMP(a_out_excl, out_valid, out_point_inside != out_face_found)
  // no result posts while the pipeline still holds faces
  `CPQ_ASSERT_IMP(a_post_drained, post, !tag1_r.valid && !dot_busy && !dot_tag.valid)

endmodule

// ===== rtl/core/cpq_dot.sv =====
module cpq_dot (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cpq_pkg::tag_t                         in_tag,
  input  logic signed [cpq_pkg::NRM_W-1:0]      nrm_x,
  input  logic signed [cpq_pkg::NRM_W-1:0]      nrm_y,
  input  logic signed [cpq_pkg::NRM_W-1:0]      nrm_z,
  input  logic signed [cpq_pkg::OFF_W-1:0]      offset,
  input  logic signed [cpq_pkg::COORD_W-1:0]    pt_x,
  input  logic signed [cpq_pkg::COORD_W-1:0]    pt_y,
  input  logic signed [cpq_pkg::COORD_W-1:0]    pt_z,
  output cpq_pkg::tag_t                         out_tag,
  output logic signed [cpq_pkg::DIST_W-1:0]     dist_out,
  output logic                                  busy
);

  localparam int EXT_W = cpq_pkg::DIST_W - cpq_pkg::OFF_W - cpq_pkg::FRAC_W;

  cpq_pkg::tag_t                        tag1_r, tag2_r;
  logic signed [cpq_pkg::PROD_W-1:0]    prod_x_r, prod_y_r, prod_z_r;
  logic signed [cpq_pkg::OFF_W-1:0]     off_r;
  logic signed [cpq_pkg::DIST_W-1:0]    dist_nxt, dist_r, off_q;

  // stage 1: three products
  always_ff @(posedge clk) begin
    prod_x_r <= nrm_x * pt_x;
    prod_y_r <= nrm_y * pt_y;
    prod_z_r <= nrm_z * pt_z;
    off_r    <= offset;
    dist_r   <= dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
    end
  end

  // stage 2: sum minus offset aligned to q.32
  always_comb begin
    off_q    = {{EXT_W{off_r[cpq_pkg::OFF_W-1]}}, off_r, {cpq_pkg::FRAC_W{1'b0}}};
    dist_nxt = cpq_pkg::DIST_W'(prod_x_r) + cpq_pkg::DIST_W'(prod_y_r)
             + cpq_pkg::DIST_W'(prod_z_r) - off_q;
  end

  assign out_tag  = tag2_r;
  assign dist_out = dist_r;
  assign busy     = tag1_r.valid;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import cpq_pkg::*;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic signed [NRM_W-1:0]   NRM_ONE = 18'sd65536;
  localparam logic signed [COORD_W-1:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX   = 32'sh7fff_ffff;

  // one input transaction, fields as raw bit vectors at port width
  typedef struct packed {
    logic               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [NRM_W-1:0]   nx;
    logic [NRM_W-1:0]   ny;
    logic [NRM_W-1:0]   nz;
    logic [OFF_W-1:0]   off;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
  } request_t;

  // one result transaction
  typedef struct packed {
    logic                  point_inside;
    logic                  face_found;
    logic [SLOT_W-1:0]     face;
    logic [OUT_DIST_W-1:0] distance;
  } verdict_t;

  // keeps its own face table and registers, predicts each query verdict
  // and checks the block's results against them in order
  class hull_scoreboard;
    logic [NRM_W-1:0]      nrm_x [MAX_FACES];
    logic [NRM_W-1:0]      nrm_y [MAX_FACES];
    logic [NRM_W-1:0]      nrm_z [MAX_FACES];
    logic [OFF_W-1:0]      offs  [MAX_FACES];
    logic [CFG_DATA_W-1:0] eps;
    logic [CNT_W-1:0]      face_count;
    verdict_t              expected_verdicts [$];
    int                    fails;

    function new();
      eps        = '0;
      face_count = 7'd1;
      fails      = 0;
      foreach (offs[i]) begin
        nrm_x[i] = '0;
        nrm_y[i] = '0;
        nrm_z[i] = '0;
        offs[i]  = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_EPS) begin
        eps = data;
      end else if (idx == CFG_FACE_COUNT) begin
        face_count = data[CNT_W-1:0];
      end
    endfunction

    function verdict_t classify_point(request_t rq);
      verdict_t v;
      longint   eps_q32;
      longint   d;
      longint   best_d;
      longint   outside_q16;
      int       n;
      int       best_i;
      bit       found;
      eps_q32 = longint'($signed(eps)) * 65536;
      n       = (face_count > MAX_FACES) ? MAX_FACES : int'(face_count);
      found   = 1'b0;
      best_i  = 0;
      best_d  = 0;
      // exact Q.32 distance, first strictly smaller one wins ties
      for (int i = 0; i < n; i++) begin
        d = longint'($signed(nrm_x[i])) * longint'($signed(rq.px))
          + longint'($signed(nrm_y[i])) * longint'($signed(rq.py))
          + longint'($signed(nrm_z[i])) * longint'($signed(rq.pz))
          - longint'($signed(offs[i])) * 65536;
        if (d > eps_q32 && (!found || d < best_d)) begin
          found  = 1'b1;
          best_d = d;
          best_i = i;
        end
      end
      outside_q16 = 0;
      if (found && best_d > 0) begin
        outside_q16 = best_d >>> 16;
        if (outside_q16 > 64'sh7fff_ffff) begin
          outside_q16 = 64'sh7fff_ffff;
        end
      end
      v.point_inside = !found;
      v.face_found   = found;
      v.face         = found ? best_i[SLOT_W-1:0] : '0;
      v.distance     = outside_q16[OUT_DIST_W-1:0];
      return v;
    endfunction

    function void note_request(request_t rq);
      if (rq.cmd == CMD_LOAD) begin
        nrm_x[rq.slot] = rq.nx;
        nrm_y[rq.slot] = rq.ny;
        nrm_z[rq.slot] = rq.nz;
        offs[rq.slot]  = rq.off;
      end else begin
        expected_verdicts = {expected_verdicts, classify_point(rq)};
      end
    endfunction

    function void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        fails++;
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        fails++;
        $display("%0t: result with no query outstanding, got %h", $time, got);
        return;
      end
      want = expected_verdicts.pop_front();
      check_field("point_inside", 64'(want.point_inside), 64'(got.point_inside));
      check_field("face_found", 64'(want.face_found), 64'(got.face_found));
      check_field("nearest_outside_face", 64'(want.face), 64'(got.face));
      check_field("outside_distance", 64'(want.distance), 64'(got.distance));
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  in_cmd    = 1'b0;
  logic [SLOT_W-1:0]     in_face_slot    = '0;
  logic [NRM_W-1:0]      in_normal_x     = '0;
  logic [NRM_W-1:0]      in_normal_y     = '0;
  logic [NRM_W-1:0]      in_normal_z     = '0;
  logic [OFF_W-1:0]      in_plane_offset = '0;
  logic [COORD_W-1:0]    in_point_x      = '0;
  logic [COORD_W-1:0]    in_point_y      = '0;
  logic [COORD_W-1:0]    in_point_z      = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_point_inside;
  logic                  out_face_found;
  logic [SLOT_W-1:0]     out_nearest_outside_face;
  logic [OUT_DIST_W-1:0] out_outside_distance;

  hull_scoreboard sb;

  // which slots hold a face, so no query ever reads an unwritten entry
  bit         face_loaded [MAX_FACES];
  logic [CNT_W-1:0] cur_count = 7'd1;
  // phase flavor: bounded hull with small points vs. wide-open values
  bit         hull_shape  = 1'b0;
  request_t   last_face   = '0;
  int         items_sent  = 0;
  int         in_burst    = 0;
  int         out_run_stall = 0;
  int         out_run_free  = 0;
  int         quiet_cycles  = 0;

  convex_polyhedron_point_query u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_cmd                   (in_cmd),
    .in_face_slot             (in_face_slot),
    .in_normal_x              (in_normal_x),
    .in_normal_y              (in_normal_y),
    .in_normal_z              (in_normal_z),
    .in_plane_offset          (in_plane_offset),
    .in_point_x               (in_point_x),
    .in_point_y               (in_point_y),
    .in_point_z               (in_point_z),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_point_inside         (out_point_inside),
    .out_face_found           (out_face_found),
    .out_nearest_outside_face (out_nearest_outside_face),
    .out_outside_distance     (out_outside_distance)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle run length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // busy run length between idles; the long ones give stretches with no idling
  function automatic int busy_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(10, 40);
    return $urandom_range(100, 300);
  endfunction

  function automatic logic [31:0] rand_span(int unsigned r);
    longint v;
    v = longint'($urandom_range(0, 2 * r)) - longint'(r);
    return v[31:0];
  endfunction

  // normal component within +-1.0, with the extremes and near-zero values
  function automatic logic [NRM_W-1:0] rand_normal();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? NRM_ONE : -NRM_ONE;
    if (r == 1) v = int'($urandom_range(0, 2)) - 1;
    else if (r < 7) v = int'($urandom_range(0, 131072)) - 65536;
    else v = int'($urandom_range(0, 8192)) - 4096;
    return v[NRM_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] rand_offset();
    int r;
    if (hull_shape) return $urandom_range(1 << 18, 1 << 24);
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
    if (r < 4) return rand_span(1 << 20);
    return $urandom();
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (hull_shape) begin
      // small points land inside the hull, medium ones mostly outside
      if (r < 7) return rand_span(1 << 18);
      if (r < 9) return rand_span(1 << 26);
      return $urandom();
    end
    if (r == 0) return Q_MIN;
    if (r == 1) return Q_MAX;
    if (r == 2) return '0;
    if (r < 6) return rand_span(1 << 20);
    return $urandom();
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_eps();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return '0;
    if (r < 12) return rand_span(1 << 16);
    if (r < 15) return $urandom();
    if (r == 15) return Q_MIN;
    if (r == 16) return Q_MAX;
    if (r == 17) return '1;
    return rand_span(1 << 22);
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return CNT_W'($urandom_range(1, 8));
    if (r < 14) return CNT_W'($urandom_range(9, 32));
    if (r < 16) return CNT_W'($urandom_range(33, 63));
    if (r < 18) return CNT_W'(MAX_FACES);
    if (r == 18) return CNT_W'($urandom_range(MAX_FACES + 1, 127));
    return '0;
  endfunction

  // fields a load does not use carry random junk
  function automatic request_t make_load(logic [SLOT_W-1:0] slot, logic [NRM_W-1:0] nx,
                                         logic [NRM_W-1:0] ny, logic [NRM_W-1:0] nz,
                                         logic [OFF_W-1:0] off);
    request_t rq;
    rq.cmd  = CMD_LOAD;
    rq.slot = slot;
    rq.nx   = nx;
    rq.ny   = ny;
    rq.nz   = nz;
    rq.off  = off;
    rq.px   = $urandom();
    rq.py   = $urandom();
    rq.pz   = $urandom();
    return rq;
  endfunction

  // fields a query does not use carry random junk
  function automatic request_t make_query(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                          logic [COORD_W-1:0] pz);
    request_t rq;
    rq.cmd  = CMD_QUERY;
    rq.slot = SLOT_W'($urandom());
    rq.nx   = NRM_W'($urandom());
    rq.ny   = NRM_W'($urandom());
    rq.nz   = NRM_W'($urandom());
    rq.off  = $urandom();
    rq.px   = px;
    rq.py   = py;
    rq.pz   = pz;
    return rq;
  endfunction

  function automatic request_t random_face(logic [SLOT_W-1:0] slot);
    return make_load(slot, rand_normal(), rand_normal(), rand_normal(), rand_offset());
  endfunction

  function automatic int active_faces();
    return (cur_count > MAX_FACES) ? MAX_FACES : int'(cur_count);
  endfunction

  // drive one input transaction, hold it until accepted, then hand it to the scoreboard
  task automatic send(request_t rq);
    int gap;
    if (in_burst > 0) begin
      in_burst--;
      gap = 0;
    end else begin
      gap      = idle_len();
      in_burst = busy_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= rq.cmd;
    in_face_slot    <= rq.slot;
    in_normal_x     <= rq.nx;
    in_normal_y     <= rq.ny;
    in_normal_z     <= rq.nz;
    in_plane_offset <= rq.off;
    in_point_x      <= rq.px;
    in_point_y      <= rq.py;
    in_point_z      <= rq.pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rq);
    if (rq.cmd == CMD_LOAD) begin
      face_loaded[rq.slot] = 1'b1;
      last_face            = rq;
    end
    items_sent++;
  endtask

  // registers change only with the block idle: every result in, then a short settle
  task automatic set_config(logic [CFG_DATA_W-1:0] eps, logic [CNT_W-1:0] count);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EPS;
    cfg_data  <= eps;
    @(posedge clk);
    sb.write_reg(CFG_EPS, eps);
    cfg_index <= CFG_FACE_COUNT;
    cfg_data  <= {{(CFG_DATA_W - CNT_W){1'b0}}, count};
    @(posedge clk);
    sb.write_reg(CFG_FACE_COUNT, {{(CFG_DATA_W - CNT_W){1'b0}}, count});
    cfg_we    <= 1'b0;
    cur_count  = count;
  endtask

  // load any face the next query would read but that was never written
  task automatic fill_faces();
    for (int i = 0; i < active_faces(); i++) begin
      if (!face_loaded[i]) send(random_face(i[SLOT_W-1:0]));
    end
  endtask

  // result side stalls in runs: short, occasionally long, with free stretches between
  always @(posedge clk) begin
    if (out_run_stall == 0 && out_run_free == 0) begin
      out_run_stall = idle_len();
      out_run_free  = busy_len();
    end
    if (out_run_stall > 0) begin
      out_run_stall--;
      out_stall <= 1'b1;
    end else begin
      out_run_free--;
      out_stall <= 1'b0;
    end
  end

  // every accepted result transaction goes to the scoreboard
  always @(posedge clk) begin : result_monitor
    verdict_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.point_inside = out_point_inside;
      got.face_found   = out_face_found;
      got.face         = out_nearest_outside_face;
      got.distance     = out_outside_distance;
      sb.check_verdict(got);
    end
  end

  // hang detector: any accepted transaction or register write resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : main_flow
    int       base;
    int       span;
    int       n;
    int       phase;
    request_t rq;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one face, point on the plane, in front of it and behind it
    set_config('0, 7'd1);
    send(make_load(6'd0, NRM_ONE, '0, '0, '0));
    send(make_query(32'sd65536, '0, '0));
    send(make_query('0, '0, '0));
    send(make_query(-32'sd65536, 32'sd123, -32'sd77));

    // zero faces in use: nothing evaluated, always inside
    set_config('0, 7'd0);
    send(make_query($urandom(), $urandom(), $urandom()));

    // extreme planes, a duplicate of face 0 for a tie, and the top slot
    send(make_load(6'd1, -NRM_ONE, -NRM_ONE, -NRM_ONE, Q_MIN));
    send(make_load(6'd2, NRM_ONE, NRM_ONE, NRM_ONE, Q_MAX));
    send(make_load(6'd3, NRM_ONE, '0, '0, '0));
    send(make_load(6'd63, -NRM_ONE, NRM_ONE, '0, '0));

    // extreme points: distance right at the 31-bit limit and far past it
    set_config('0, 7'd4);
    send(make_query(Q_MAX, Q_MAX, Q_MAX));
    send(make_query(Q_MIN, Q_MIN, Q_MIN));

    // lowest eps: nearest outside face has a negative distance, reported as zero
    set_config(Q_MIN, 7'd4);
    send(make_query('0, '0, '0));

    // highest eps: one face just above it, distance saturates
    set_config(Q_MAX, 7'd4);
    send(make_query('0, '0, '0));

    // eps slightly negative: two equal distances, lower index reported
    set_config('1, 7'd4);
    send(make_query('0, '0, '0));

    // random phases, each under its own register setting
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      hull_shape = ($urandom_range(0, 1) != 0);
      case (phase)
        0:       set_config(rand_eps(), CNT_W'(MAX_FACES));
        1:       set_config(rand_eps(), 7'd127);
        2:       set_config(rand_eps(), 7'd0);
        default: set_config(rand_eps(), rand_count());
      endcase
      n    = active_faces();
      span = $urandom_range(40, 160);
      for (int k = 0; k < span && items_sent - base < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 35) begin
          // reload a face, mostly one in use, sometimes a copy of the last one
          if (n > 0 && $urandom_range(0, 9) < 7) begin
            rq = random_face(SLOT_W'($urandom_range(0, n - 1)));
          end else begin
            rq = random_face(SLOT_W'($urandom_range(0, MAX_FACES - 1)));
          end
          if ($urandom_range(0, 7) == 0 && last_face.cmd == CMD_LOAD) begin
            last_face.slot = rq.slot;
            rq             = last_face;
          end
          send(rq);
        end else begin
          fill_faces();
          send(make_query(rand_coord(), rand_coord(), rand_coord()));
        end
      end
      phase++;
    end

    // drain: every expected result in, then the DRAIN_CYCLES wait for strays
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
